>>> rtl/core/fbfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_pkg
// Types and fixed widths shared by the block free list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

    localparam int OPCODE_W = 1;
    localparam int INDEX_W  = 11;
    localparam int STATUS_W = 2;
    localparam int GRANT_W  = 10;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_EXHAUSTED    = 2'd1,
        ST_BAD_INDEX    = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } status_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_BAD   = 2'd2
    } kind_t;

    typedef enum logic {
        BK_READ = 1'b0,
        BK_EXEC = 1'b1
    } back_state_t;

    typedef struct packed {
        logic push;
        logic full;
    } queue_ctl_t;

endpackage

>>> rtl/core/fixed_block_free_list_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Pool allocator for equal-size blocks kept as a LIFO free list.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_stall  | opcode, block_index
//   rsp     | out | rsp_valid/rsp_stall  | status, granted_block
//
// Each item is a synchronous read of the link and mark memories, then an
// update; the next item is taken only once the update is done.
// A two-entry queue lets requests arrive while the result register is stalled.
// No clearing pass after reset: a watermark marks blocks never handed out.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator
    import fbfl_pkg::*;
#(
    parameter int NUM_BLOCKS = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [INDEX_W-1:0]  block_index,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [GRANT_W-1:0]  granted_block
);

    localparam int IDX_W  = $clog2(NUM_BLOCKS);
    localparam int LINK_W = $clog2(NUM_BLOCKS + 1);
    localparam int Q_W    = 2 + IDX_W;

    queue_ctl_t       q_ctl;
    logic             q_full;
    kind_t            f_kind;
    logic [IDX_W-1:0] f_idx;
    logic [Q_W-1:0]   q_rd_data;
    logic             q_valid;
    logic             q_pop;
    kind_t            q_kind;
    logic [IDX_W-1:0] q_idx;

    assign q_kind = kind_t'(q_rd_data[Q_W-1 -: 2]);
    assign q_idx  = q_rd_data[IDX_W-1:0];

    fbfl_front #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .IDX_W      (IDX_W)
    ) u_front (
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .opcode      (opcode),
        .block_index (block_index),
        .q_full      (q_full),
        .q_ctl       (q_ctl),
        .kind        (f_kind),
        .idx         (f_idx)
    );

    fbfl_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (q_ctl),
        .wr_data  ({f_kind, f_idx}),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data)
    );

    fbfl_back #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .IDX_W      (IDX_W),
        .LINK_W     (LINK_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_kind        (q_kind),
        .q_idx         (q_idx),
        .q_pop         (q_pop),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .granted_block (granted_block)
    );

endmodule

>>> rtl/core/fbfl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_front
// Request intake: classifies each item as allocate, free or bad index.
// ----------------------------------------------------------------------------
module fbfl_front
    import fbfl_pkg::*;
#(
    parameter int NUM_BLOCKS = 1024,
    parameter int IDX_W      = 10
)
(
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [INDEX_W-1:0] block_index,
    input  logic               q_full,
    output queue_ctl_t         q_ctl,
    output kind_t              kind,
    output logic [IDX_W-1:0]   idx
);

    logic [31:0] index_wide;

    assign index_wide  = 32'(block_index);
    assign idx         = index_wide[IDX_W-1:0];
    assign req_stall   = q_full;
    assign q_ctl.push  = req_valid && !q_full;
    assign q_ctl.full  = q_full;

    always_comb
    begin
        case (opcode_t'(opcode))
            OP_ALLOC: kind = KIND_ALLOC;
            OP_FREE:  kind = (index_wide >= 32'(NUM_BLOCKS)) ? KIND_BAD : KIND_FREE;
            default:  kind = KIND_BAD;
        endcase
    end

endmodule

>>> rtl/core/fbfl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_queue
// Two-entry queue between request intake and execution.
// ----------------------------------------------------------------------------
module fbfl_queue
    import fbfl_pkg::*;
#(
    parameter int DATA_W = 12
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  queue_ctl_t        ctl,
    input  logic [DATA_W-1:0] wr_data,
    output logic              full,
    input  logic              pop,
    output logic              rd_valid,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_push  = ctl.push && !ctl.full;
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/core/fbfl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_back
// Execution: free list head, link and mark memories, result register.
// Blocks at or above the watermark were never handed out; they are free and
// link to the next index, so the memories need no clearing pass.
// ----------------------------------------------------------------------------
module fbfl_back
    import fbfl_pkg::*;
#(
    parameter int NUM_BLOCKS = 1024,
    parameter int IDX_W      = 10,
    parameter int LINK_W     = 11
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  kind_t               q_kind,
    input  logic [IDX_W-1:0]    q_idx,
    output logic                q_pop,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [GRANT_W-1:0]  granted_block
);

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_BLOCKS);

    logic [LINK_W-1:0] link_mem [NUM_BLOCKS];
    logic              mark_mem [NUM_BLOCKS];

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [LINK_W-1:0]  head_reg;
    logic [LINK_W-1:0]  head_next;
    logic [LINK_W-1:0]  wmark_reg;
    logic [LINK_W-1:0]  wmark_next;
    kind_t              kind_reg;
    kind_t              kind_next;
    logic [IDX_W-1:0]   addr_reg;
    logic [IDX_W-1:0]   addr_next;
    logic [LINK_W-1:0]  link_rd_reg;
    logic               mark_rd_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    status_t            status_reg;
    status_t            status_next;
    logic [GRANT_W-1:0] grant_reg;
    logic [GRANT_W-1:0] grant_next;

    logic               take;
    logic               rd_en;
    logic               wr_en;
    logic [LINK_W-1:0]  wr_link;
    logic               wr_mark;
    logic [LINK_W-1:0]  addr_link;
    logic               untouched;
    logic [31:0]        head_wide;

    assign addr_link     = LINK_W'(addr_reg);
    assign untouched     = (addr_link >= wmark_reg);
    assign head_wide     = 32'(head_reg);
    assign take          = (state_reg == BK_READ) && q_valid
                           && (!out_valid_reg || !rsp_stall);
    assign q_pop         = take;
    assign rd_en         = take;
    assign rsp_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_block = grant_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        wmark_next     = wmark_reg;
        kind_next      = kind_reg;
        addr_next      = addr_reg;
        status_next    = status_reg;
        grant_next     = grant_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        wr_en          = 1'b0;
        wr_link        = NULL_LINK;
        wr_mark        = 1'b0;
        case (state_reg)
            BK_READ:
            begin
                if (take)
                begin
                    kind_next  = q_kind;
                    addr_next  = (q_kind == KIND_ALLOC) ? head_reg[IDX_W-1:0] : q_idx;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                out_valid_next = 1'b1;
                status_next    = ST_OK;
                grant_next     = '0;
                state_next     = BK_READ;
                case (kind_reg)
                    KIND_ALLOC:
                    begin
                        if (head_reg == NULL_LINK)
                        begin
                            status_next = ST_EXHAUSTED;
                        end
                        else
                        begin
                            grant_next = head_wide[GRANT_W-1:0];
                            wr_en      = 1'b1;
                            wr_link    = NULL_LINK;
                            wr_mark    = 1'b0;
                            if (untouched)
                            begin
                                head_next  = head_reg + LINK_W'(1);
                                wmark_next = wmark_reg + LINK_W'(1);
                            end
                            else
                            begin
                                head_next = link_rd_reg;
                            end
                        end
                    end
                    KIND_FREE:
                    begin
                        if (untouched || mark_rd_reg)
                        begin
                            status_next = ST_ALREADY_FREE;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_link   = head_reg;
                            wr_mark   = 1'b1;
                            head_next = addr_link;
                        end
                    end
                    default:
                    begin
                        status_next = ST_BAD_INDEX;
                    end
                endcase
            end
            default:
            begin
                state_next = BK_READ;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_READ;
            head_reg      <= '0;
            wmark_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            wmark_reg     <= wmark_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        addr_reg   <= addr_next;
        status_reg <= status_next;
        grant_reg  <= grant_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[addr_reg] <= wr_link;
        end
        if (rd_en)
        begin
            link_rd_reg <= link_mem[addr_next];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mark_mem[addr_reg] <= wr_mark;
        end
        if (rd_en)
        begin
            mark_rd_reg <= mark_mem[addr_next];
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fixed block free list allocator. Requests go in
// on a valid/stall channel, and a scoreboard keeps its own copy of the free
// list. It predicts each response and compares it, field by field, in order.
// The stimulus starts with directed corner items. It then runs random
// allocate and free traffic that drains the pool to exhaustion and refills it.
// Idle patterns vary on both channels, and one long receiver hold-off backs
// the block up.
// ----------------------------------------------------------------------------
module testbench;

    import fbfl_pkg::*;

    localparam int NUM_BLOCKS = 1024;
    localparam int MAX_INDEX  = (1 << INDEX_W) - 1;
    localparam int ITEMS_PER_PHASE = 500;
    localparam int HOLD_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        status_t            status;
        logic [GRANT_W-1:0] block;
    } alloc_result_t;

    class alloc_scoreboard;
        logic [INDEX_W-1:0] head;
        logic [INDEX_W-1:0] link [NUM_BLOCKS];
        bit                 is_free [NUM_BLOCKS];
        int unsigned        in_use [$];
        alloc_result_t      pending [$];
        int                 errors;
        int                 exhausted_count;

        function new();
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                link[i]    = INDEX_W'(i + 1);
                is_free[i] = 1'b1;
            end
            head            = '0;
            errors          = 0;
            exhausted_count = 0;
        endfunction

        function void note_request(opcode_t op, logic [INDEX_W-1:0] idx);
            alloc_result_t      res;
            logic [INDEX_W-1:0] blk;
            res.status = ST_OK;
            res.block  = '0;
            if (op == OP_ALLOC)
            begin
                if (head >= NUM_BLOCKS)
                begin
                    res.status = ST_EXHAUSTED;
                    exhausted_count++;
                end
                else
                begin
                    blk          = head;
                    head         = link[blk];
                    is_free[blk] = 1'b0;
                    link[blk]    = INDEX_W'(NUM_BLOCKS);
                    res.block    = blk[GRANT_W-1:0];
                    in_use.push_back(blk);
                end
            end
            else
            begin
                if (idx >= NUM_BLOCKS)
                    res.status = ST_BAD_INDEX;
                else if (is_free[idx])
                    res.status = ST_ALREADY_FREE;
                else
                begin
                    is_free[idx] = 1'b1;
                    link[idx]    = head;
                    head         = idx;
                    foreach (in_use[k])
                    begin
                        if (in_use[k] == idx)
                        begin
                            in_use.delete(k);
                            break;
                        end
                    end
                end
            end
            pending.push_back(res);
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [STATUS_W-1:0] st, logic [GRANT_W-1:0] blk);
            alloc_result_t exp_res;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected response status=%0d block=%0d", st, blk));
                return;
            end
            exp_res = pending.pop_front();
            if (st !== exp_res.status)
                report($sformatf("status got %0d expected %s", st, exp_res.status.name()));
            if (blk !== exp_res.block)
                report($sformatf("granted_block got %0d expected %0d", blk, exp_res.block));
        endtask

        task flag_leftovers();
            while (pending.size() != 0)
            begin
                void'(pending.pop_front());
                report("expected response never arrived");
            end
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic [OPCODE_W-1:0] opcode = '0;
    logic [INDEX_W-1:0]  block_index = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [GRANT_W-1:0]  granted_block;

    alloc_scoreboard sb;
    int  send_idle_pct = 24;
    int  rcv_idle_pct = 87;
    bit  hold_go = 1'b0;
    bit  hold_done = 1'b0;
    bit  draining = 1'b1;
    int  exhausted_mark = 0;
    int  idle_cycles = 0;

    fixed_block_free_list_allocator #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .opcode       (opcode),
        .block_index  (block_index),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .granted_block(granted_block)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic send(opcode_t op, logic [INDEX_W-1:0] idx);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid   <= 1'b1;
        opcode      <= op;
        block_index <= idx;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(op, idx);
    endtask

    // alternate between draining the pool to exhaustion and refilling it
    task automatic send_random();
        opcode_t            op;
        logic [INDEX_W-1:0] idx;
        int                 r;
        if (draining && sb.exhausted_count - exhausted_mark >= 15)
            draining = 1'b0;
        else if (!draining && sb.in_use.size() < 20)
        begin
            draining       = 1'b1;
            exhausted_mark = sb.exhausted_count;
        end
        idx = INDEX_W'($urandom_range(0, MAX_INDEX));
        op  = ($urandom_range(0, 99) < (draining ? 90 : 10)) ? OP_ALLOC : OP_FREE;
        if (op == OP_FREE)
        begin
            r = $urandom_range(0, 99);
            if (r < 70 && sb.in_use.size() != 0)
                idx = INDEX_W'(sb.in_use[$urandom_range(0, sb.in_use.size() - 1)]);
            else if (r < 85)
                idx = INDEX_W'($urandom_range(0, NUM_BLOCKS - 1));
            else
                idx = INDEX_W'($urandom_range(NUM_BLOCKS, MAX_INDEX));
        end
        send(op, idx);
    endtask

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_ALLOC, '0);
        send(OP_ALLOC, INDEX_W'(MAX_INDEX));
        send(OP_FREE, INDEX_W'(MAX_INDEX));
        send(OP_FREE, INDEX_W'(NUM_BLOCKS));
        send(OP_FREE, INDEX_W'(NUM_BLOCKS - 1));
        send(OP_FREE, INDEX_W'(0));
        send(OP_FREE, INDEX_W'(0));
        send(OP_ALLOC, '0);
        send(OP_ALLOC, '0);
        send(OP_FREE, INDEX_W'(1));
        send(OP_FREE, INDEX_W'(2));
        send(OP_ALLOC, '0);
        send(OP_ALLOC, INDEX_W'(MAX_INDEX));
        send(OP_ALLOC, '0);
        send(OP_FREE, INDEX_W'(5));
        send(OP_FREE, INDEX_W'(1));
        send(OP_FREE, INDEX_W'(1));
        send(OP_FREE, INDEX_W'(3));
        send(OP_ALLOC, '0);
        send(OP_ALLOC, '0);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 24;
                    rcv_idle_pct  = 87;
                end
                1:
                begin
                    send_idle_pct = 87;
                    rcv_idle_pct  = 24;
                end
                default:
                begin
                    send_idle_pct = 0;
                    rcv_idle_pct  = 0;
                    hold_go       = 1'b1;
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_random();
        end
        req_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.flag_leftovers();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // receiver stall, with one long hold-off once the last phase starts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    rsp_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(status, granted_block);
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

>>> fixed_block_free_list_allocator.f
rtl/core/fbfl_pkg.sv
rtl/core/fbfl_front.sv
rtl/core/fbfl_queue.sv
rtl/core/fbfl_back.sv
rtl/core/fixed_block_free_list_allocator.sv
tb/testbench.sv
